FILE: design/vumb_pkg.sv
package vumb_pkg;

  // field widths
  localparam int DB_W       = 16;
  localparam int ANG_W      = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // log2 and dB conversion
  localparam int LEVEL_FRAC_BITS = 20;
  localparam int LOG_STEPS       = 8;
  localparam int STEP_W          = $clog2(LOG_STEPS);
  localparam int OCT_W           = 6;
  localparam int LOG_W           = OCT_W + LOG_STEPS;
  localparam int DB_PER_OCT_Q16  = 394566;
  localparam int MUL_MIN_W       = 20;

  // reset values of the configuration registers
  localparam logic [CFG_DATA_W-1:0]        COEFF_RESET   = 16'd9830;
  localparam logic signed [CFG_DATA_W-1:0] SILENCE_RESET = -16'sd15360;

  // needle scale
  localparam int SCALE_POINTS = 10;
  localparam int SEGS         = SCALE_POINTS - 1;
  localparam int SEG_W        = $clog2(SEGS);
  localparam int OFF_W        = 12;
  localparam int SCALE_FRAC   = 8;
  localparam int DIV_N_W      = 16;

  localparam logic signed [DB_W-1:0] SCALE_DB [SCALE_POINTS] = '{
    -16'sd5120, -16'sd2560, -16'sd1792, -16'sd1280, -16'sd768,
    -16'sd256, 16'sd0, 16'sd256, 16'sd512, 16'sd768
  };
  localparam logic signed [DB_W-1:0] SCALE_ANG [SCALE_POINTS] = '{
    -16'sd12800, -16'sd7168, -16'sd4352, -16'sd2048, 16'sd512,
    16'sd3584, 16'sd6400, 16'sd8448, 16'sd9984, 16'sd12800
  };
  // angle rise of each segment
  localparam logic [15:0] SEG_SLOPE [SEGS] = '{
    16'd5632, 16'd2816, 16'd2304, 16'd2560, 16'd3072,
    16'd2816, 16'd2048, 16'd1536, 16'd2816
  };
  // segment width is k*256: quotient by k as multiply and shift
  localparam logic [15:0] SEG_RECIP [SEGS] = '{
    16'd52429, 16'd43691, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1
  };
  localparam logic [4:0] SEG_SHIFT [SEGS] = '{
    5'd19, 5'd17, 5'd1, 5'd1, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF   = 1'b0,
    REG_SILENCE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_SQ  = 3'd0,
    MUL_DB  = 3'd1,
    MUL_SM  = 3'd2,
    MUL_INT = 3'd3,
    MUL_DIV = 3'd4
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     norm_shift;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     sq_fix;
    logic     tgt_silence;
    logic     tgt_log;
    logic     sm_update;
    logic     seg_load;
    logic     ang_load;
    logic     out_load;
  } vumb_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic m_norm;
    logic clamp;
  } vumb_sts_t;

endpackage

FILE: design/vumb_level_if.sv
interface vumb_level_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] rms_level;

  modport source (output valid, output rms_level, input ready);
  modport sink (input valid, input rms_level, output ready);
endinterface

FILE: design/vumb_meter_if.sv
interface vumb_meter_if import vumb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DB_W-1:0]  level_db;
  logic signed [ANG_W-1:0] needle_angle;

  modport source (output valid, output level_db, output needle_angle, input ready);
  modport sink (input valid, input level_db, input needle_angle, output ready);
endinterface

FILE: design/vu_meter_ballistics_core.sv
// channel   dir  handshake      payload
// level_i   in   valid/ready    rms_level (SAMPLE_BITS, unsigned Q4.20)
// meter_o   out  valid/ready    level_db (16, signed Q8.8), needle_angle (15, signed Q7.8)
// cfg       in   cfg_we_i       cfg_idx_i selects coeff or silence floor, cfg_data_i 16 bits
//
// one request at a time; the time from request to result grows with z = leading zeros of
// rms_level, set by the one-bit-a-cycle normalize loop, and with eight squarings on the
// shared multiplier; a clamped level skips interpolation, zero input skips the log steps
// next request is taken in the cycle after the result goes to the output register
// a stalled output holds only the finished result; the core waits in idle until it is free
// async active-low reset loads the default coeff and silence floor, clears the kept level
module vu_meter_ballistics_core import vumb_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  vumb_level_if.sink            level_i,
  vumb_meter_if.source          meter_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  vumb_cmd_t cmd;
  vumb_sts_t sts;

  // sequencer
  vumb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (level_i.valid),
    .in_ready_o  (level_i.ready),
    .out_valid_o (meter_o.valid),
    .out_ready_i (meter_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // log, smoothing and scale datapath
  vumb_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rms_level_i    (level_i.rms_level),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .level_db_o     (meter_o.level_db),
    .needle_angle_o (meter_o.needle_angle)
  );

endmodule

FILE: design/vumb_ctrl.sv
module vumb_ctrl import vumb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  vumb_sts_t sts_i,
  output vumb_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_NORM   = 12'b000000000010,
    S_SQ     = 12'b000000000100,
    S_SQFIX  = 12'b000000001000,
    S_DB     = 12'b000000010000,
    S_DBUSE  = 12'b000000100000,
    S_SM     = 12'b000001000000,
    S_SMUSE  = 12'b000010000000,
    S_SEG    = 12'b000100000000,
    S_INT    = 12'b001000000000,
    S_DIV    = 12'b010000000000,
    S_DIVUSE = 12'b100000000000
  } state_e;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LOG_STEPS - 1);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              done_q, done_d;
  logic              out_free;
  logic              in_acc;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && !done_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = done_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_SQ;
    unique case (state_q)
      S_IDLE: begin
        // finished result waits here for the output register
        if (done_q) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            done_d = 1'b0;
          end
        end else if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (sts_i.m_zero) begin
          cmd_o.tgt_silence = 1'b1;
          state_d = S_SM;
        end else if (sts_i.m_norm) begin
          step_d  = '0;
          state_d = S_SQ;
        end else begin
          cmd_o.norm_shift = 1'b1;
        end
      end
      S_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SQ;
        state_d = S_SQFIX;
      end
      S_SQFIX: begin
        cmd_o.sq_fix = 1'b1;
        step_d = step_q + STEP_W'(1);
        state_d = (step_q == LAST_STEP) ? S_DB : S_SQ;
      end
      S_DB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DB;
        state_d = S_DBUSE;
      end
      S_DBUSE: begin
        cmd_o.tgt_log = 1'b1;
        state_d = S_SM;
      end
      S_SM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SM;
        state_d = S_SMUSE;
      end
      S_SMUSE: begin
        cmd_o.sm_update = 1'b1;
        state_d = S_SEG;
      end
      S_SEG: begin
        cmd_o.seg_load = 1'b1;
        if (sts_i.clamp) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_INT;
        end
      end
      S_INT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_INT;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DIV;
        state_d = S_DIVUSE;
      end
      S_DIVUSE: begin
        cmd_o.ang_load = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      done_q      <= done_d;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free)
    else $error("result loaded over an unread result");

  a_all_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DB) |-> ($past(state_q) == S_SQFIX && $past(step_q) == LAST_STEP))
    else $error("dB scaling started before all squaring steps");

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !done_q)
    else $error("request taken while a result is still pending");

endmodule

FILE: design/vumb_dp.sv
module vumb_dp import vumb_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vumb_cmd_t                     cmd_i,
  output vumb_sts_t                     sts_o,
  input  logic [SAMPLE_BITS-1:0]        rms_level_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  output logic signed [DB_W-1:0]        level_db_o,
  output logic signed [ANG_W-1:0]       needle_angle_o
);

  localparam int MW = (SAMPLE_BITS + 1 > MUL_MIN_W) ? SAMPLE_BITS + 1 : MUL_MIN_W;
  localparam int PW = 2 * MW;
  localparam int TW = $clog2(SAMPLE_BITS);

  // configuration and kept level
  logic [CFG_DATA_W-1:0]        coeff_q;
  logic signed [CFG_DATA_W-1:0] silence_q;
  logic signed [DB_W-1:0]       smoothed_q;

  // working registers
  logic [SAMPLE_BITS-1:0]  m_q;
  logic [TW-1:0]           top_q;
  logic [LOG_STEPS-1:0]    frac_q;
  logic signed [PW-1:0]    p_q;
  logic signed [DB_W-1:0]  target_q;
  logic [SEG_W-1:0]        seg_q;
  logic [OFF_W-1:0]        off_q;
  logic signed [ANG_W-1:0] angle_q;
  logic signed [DB_W-1:0]  level_db_q;
  logic signed [ANG_W-1:0] needle_q;

  logic signed [OCT_W-1:0] oct;
  logic signed [LOG_W-1:0] log2_val;
  logic [SAMPLE_BITS:0]    m2;
  logic signed [DB_W:0]    diff;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic                    clamp_lo, clamp_hi, found;
  logic [SEG_W-1:0]        seg_d;
  logic [31:0]             quot;

  assign oct      = $signed(OCT_W'(top_q) - OCT_W'(LEVEL_FRAC_BITS));
  assign log2_val = $signed({oct, frac_q});
  assign m2       = p_q[SAMPLE_BITS-1 +: SAMPLE_BITS+1];
  assign diff     = $signed({target_q[DB_W-1], target_q}) -
                    $signed({smoothed_q[DB_W-1], smoothed_q});
  assign quot     = p_q[31:0] >> SEG_SHIFT[seg_q];

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_SQ: begin
        mul_a = $signed({{(MW-SAMPLE_BITS){1'b0}}, m_q});
        mul_b = $signed({{(MW-SAMPLE_BITS){1'b0}}, m_q});
      end
      MUL_DB: begin
        mul_a = MW'(log2_val);
        mul_b = MW'(DB_PER_OCT_Q16);
      end
      MUL_SM: begin
        mul_a = MW'(diff);
        mul_b = $signed(MW'(coeff_q));
      end
      MUL_INT: begin
        mul_a = $signed(MW'(off_q));
        mul_b = $signed(MW'(SEG_SLOPE[seg_q]));
      end
      MUL_DIV: begin
        mul_a = $signed(MW'(p_q[SCALE_FRAC +: DIV_N_W]));
        mul_b = $signed(MW'(SEG_RECIP[seg_q]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // scale segment lookup for the kept level
  always_comb begin
    clamp_lo = (smoothed_q <= SCALE_DB[0]);
    clamp_hi = (smoothed_q >= SCALE_DB[SCALE_POINTS-1]);
    seg_d    = '0;
    found    = 1'b0;
    for (int i = 0; i < SEGS; i++) begin
      if (!found && smoothed_q <= SCALE_DB[i+1]) begin
        seg_d = SEG_W'(i);
        found = 1'b1;
      end
    end
  end

  assign sts_o.m_zero = (m_q == '0);
  assign sts_o.m_norm = m_q[SAMPLE_BITS-1];
  assign sts_o.clamp  = clamp_lo || clamp_hi;

  // configuration registers and smoothed level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q    <= COEFF_RESET;
      silence_q  <= SILENCE_RESET;
      smoothed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_COEFF:   coeff_q   <= cfg_data_i;
          REG_SILENCE: silence_q <= $signed(cfg_data_i);
        endcase
      end
      // floor of coeff * diff / 65536, wraps back into range
      if (cmd_i.sm_update) begin
        smoothed_q <= smoothed_q + $signed(p_q[16 +: DB_W]);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q    <= rms_level_i;
      top_q  <= TW'(SAMPLE_BITS - 1);
      frac_q <= '0;
    end else if (cmd_i.norm_shift) begin
      m_q   <= {m_q[SAMPLE_BITS-2:0], 1'b0};
      top_q <= top_q - TW'(1);
    end else if (cmd_i.sq_fix) begin
      if (m2[SAMPLE_BITS]) begin
        m_q    <= m2[SAMPLE_BITS:1];
        frac_q <= {frac_q[LOG_STEPS-2:0], 1'b1};
      end else begin
        m_q    <= m2[SAMPLE_BITS-1:0];
        frac_q <= {frac_q[LOG_STEPS-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_en) begin
      p_q <= mul_a * mul_b;
    end
    if (cmd_i.tgt_silence) begin
      target_q <= silence_q;
    end else if (cmd_i.tgt_log) begin
      target_q <= $signed(p_q[16 +: DB_W]);
    end
    if (cmd_i.seg_load) begin
      seg_q <= seg_d;
      off_q <= OFF_W'(smoothed_q - SCALE_DB[seg_d]);
      angle_q <= clamp_lo ? ANG_W'(SCALE_ANG[0]) : ANG_W'(SCALE_ANG[SCALE_POINTS-1]);
    end else if (cmd_i.ang_load) begin
      angle_q <= ANG_W'(SCALE_ANG[seg_q] + $signed(DB_W'(quot)));
    end
    if (cmd_i.out_load) begin
      level_db_q <= smoothed_q;
      needle_q   <= angle_q;
    end
  end

  assign level_db_o     = level_db_q;
  assign needle_angle_o = needle_q;

  a_sm_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sm_update |=>
      (($past(target_q) >= $past(smoothed_q)) ?
        (smoothed_q >= $past(smoothed_q) && smoothed_q <= $past(target_q)) :
        (smoothed_q <= $past(smoothed_q) && smoothed_q >= $past(target_q))))
    else $error("smoothed level left the old-to-target interval");

  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sq_fix |=> m_q[SAMPLE_BITS-1])
    else $error("mantissa lost its leading one after a squaring step");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ang_load |=> (angle_q >= SCALE_ANG[0] && angle_q <= SCALE_ANG[SCALE_POINTS-1]))
    else $error("interpolated angle outside the scale");

endmodule
